// ===== sv/dedup_set_table_assert.svh =====
// ----------------------------------------------------------------------------
// dedup_set_table_assert.svh
// Assertion macros for the set table RTL.
// ----------------------------------------------------------------------------
`ifndef DEDUP_SET_TABLE_ASSERT_SVH
`define DEDUP_SET_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dst_pkg.sv =====
// ----------------------------------------------------------------------------
// dst_pkg
// Types, sizes and codes shared by the set table modules.
// ----------------------------------------------------------------------------
package dst_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef struct packed {
        logic   we;
        idx_t   addr;
        value_t data;
    } ram_wr_t;

endpackage

// ===== sv/dedup_set_table.sv =====
// ----------------------------------------------------------------------------
// dedup_set_table
// Set of distinct values in an entry memory: add, remove and membership test.
// ----------------------------------------------------------------------------
// The scan reads one entry per cycle up to the match or the count, and is skipped
// on an empty set; S_DECIDE then applies the operation, a remove that fills the hole
// passes through S_MOVE, and S_DONE loads the output register with the result.
// One item at a time (single read port): in_stall holds off a new item until
// the last one has left S_DONE. A finished result waits in the output register.
// Reset clears the count and control state; entries stay undefined.
module dedup_set_table
    import dst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] item_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        was_present,
    output logic [1:0]  status,
    output logic [4:0]  member_count
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;
    cnt_t       count_reg, count_next;
    logic       out_valid_reg, out_valid_next;

    logic [1:0] op_reg, op_next;
    value_t     val_reg, val_next;
    idx_t       scan_idx_reg, scan_idx_next;
    logic       found_reg, found_next;
    idx_t       slot_reg, slot_next;
    logic [1:0] res_status_reg, res_status_next;
    logic       out_present_reg, out_present_next;
    logic [1:0] out_status_reg, out_status_next;
    cnt_t       out_count_reg, out_count_next;

    ram_wr_t wr;
    idx_t    rd_addr;
    value_t  rd_data;
    logic    hit;
    logic    last_scan;
    idx_t    last_idx;

    dst_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign hit       = (rd_data == val_reg);
    assign last_scan = ((CNT_W'(scan_idx_reg) + 1'b1) == count_reg);
    assign last_idx  = IDX_W'(count_reg - 1'b1);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        op_next          = op_reg;
        val_next         = val_reg;
        scan_idx_next    = scan_idx_reg;
        found_next       = found_reg;
        slot_next        = slot_reg;
        res_status_next  = res_status_reg;
        out_present_next = out_present_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        rd_addr          = '0;
        wr               = '0;
        in_stall         = (state_reg != S_IDLE);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = opcode;
                    val_next        = item_value[VALUE_BITS-1:0];
                    scan_idx_next   = '0;
                    found_next      = 1'b0;
                    res_status_next = ST_OK;
                    state_next      = (count_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Read data is registered, so fetch the next entry while this one is compared.
                rd_addr = IDX_W'(scan_idx_reg + 1'b1);
                if (hit)
                begin
                    found_next = 1'b1;
                    slot_next  = scan_idx_reg;
                    state_next = S_DECIDE;
                end
                else if (last_scan)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    scan_idx_next = IDX_W'(scan_idx_reg + 1'b1);
                end
            end
            S_DECIDE:
            begin
                rd_addr    = last_idx;
                state_next = S_DONE;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (!found_reg)
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr.we      = 1'b1;
                                wr.addr    = IDX_W'(count_reg);
                                wr.data    = val_reg;
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!found_reg)
                        begin
                            res_status_next = ST_ABSENT;
                        end
                        else if (slot_reg == last_idx)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            state_next = S_MOVE;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_MOVE:
            begin
                // The last entry fills the hole left by the removed value.
                wr.we      = 1'b1;
                wr.addr    = slot_reg;
                wr.data    = rd_data;
                count_next = count_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_present_next = found_reg;
                    out_status_next  = res_status_reg;
                    out_count_next   = count_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        val_reg         <= val_next;
        scan_idx_reg    <= scan_idx_next;
        found_reg       <= found_next;
        slot_reg        <= slot_next;
        res_status_reg  <= res_status_next;
        out_present_reg <= out_present_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign was_present  = out_present_reg;
    assign status       = out_status_reg;
    assign member_count = 5'(out_count_reg);

    `include "dedup_set_table_assert.svh"

    `DST_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY),
        "count above capacity")
    `DST_ASSERT_SAME(a_full_means_full, out_valid && (status == ST_FULL),
        (member_count == 5'(CAPACITY)) && !was_present, "full result with room left")
    `DST_ASSERT_SAME(a_write_states, wr.we,
        (state_reg == S_DECIDE) || (state_reg == S_MOVE), "entry write outside update states")
    `DST_ASSERT_NEXT(a_move_shrinks, state_reg == S_MOVE,
        count_reg == $past(count_reg) - 1'b1, "hole fill did not shrink count")

endmodule

// ===== sv/dst_ram.sv =====
// ----------------------------------------------------------------------------
// dst_ram
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dst_ram
    import dst_pkg::*;
(
    input  logic    clk,
    input  ram_wr_t wr,
    input  idx_t    rd_addr,
    output value_t  rd_data
);

    value_t mem [CAPACITY];
    value_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== dv/tb_dedup_set_table.sv =====
// ----------------------------------------------------------------------------
// tb_dedup_set_table
// Self-checking bench for the set table. Every accepted request updates a
// behavioral copy of the set, and the result that it predicts is queued and
// compared field by field with what the block returns. Both sides idle at
// random, and the receiver holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_dedup_set_table;
    import dst_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         POOL_N    = 24;
    localparam int         MAX_IDLE  = 12;
    localparam int         SETTLE    = CAPACITY + 8;

    typedef struct packed {
        logic       was_present;
        logic [1:0] status;
        logic [4:0] member_count;
    } set_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [31:0] item_value;
    logic        out_valid;
    logic        out_stall;
    logic        was_present;
    logic [1:0]  status;
    logic [4:0]  member_count;

    // Behavioral copy of the set, in insertion order.
    value_t      set_vals [CAPACITY];
    int unsigned set_size;

    set_result_t pending_results [$];
    value_t      value_pool [POOL_N];

    bit          tx_idle_on;
    bit          rx_idle_on;
    int unsigned rx_hold_cycles;

    int unsigned num_sent;
    int unsigned num_checked;
    int unsigned num_errors;
    int unsigned num_full;
    int unsigned num_absent;
    int unsigned num_hits;

    dedup_set_table u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .item_value   (item_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .was_present  (was_present),
        .status       (status),
        .member_count (member_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb_dedup_set_table: errors");
        $finish;
    end

    // Applies one request to the set copy and returns the result it yields.
    function automatic set_result_t apply_request(input logic [1:0] op, input value_t v);
        int          slot;
        set_result_t r;
        slot = -1;
        for (int i = 0; i < set_size; i++)
        begin
            if (slot < 0 && set_vals[i] == v)
                slot = i;
        end
        r.was_present = (slot >= 0);
        r.status      = ST_OK;
        case (op)
            OP_ADD:
            begin
                if (slot < 0)
                begin
                    if (set_size >= CAPACITY)
                        r.status = ST_FULL;
                    else
                    begin
                        set_vals[set_size] = v;
                        set_size++;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (slot < 0)
                    r.status = ST_ABSENT;
                else
                begin
                    for (int j = slot; j + 1 < set_size; j++)
                        set_vals[j] = set_vals[j + 1];
                    set_size--;
                end
            end
            default:
            begin
            end
        endcase
        r.member_count = set_size[4:0];
        return r;
    endfunction

    function automatic logic [1:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OP_ADD;
        if (r < 70)
            return OP_REMOVE;
        if (r < 92)
            return OP_TEST;
        return OP_UNUSED;
    endfunction

    // Mostly values from a small pool so that hits and removes happen often.
    function automatic value_t pick_value();
        if ($urandom_range(0, 99) < 80)
            return value_pool[$urandom_range(0, POOL_N - 1)];
        return value_t'($urandom());
    endfunction

    task automatic send_request(input logic [1:0] op, input value_t v);
        int unsigned gap;
        set_result_t r;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        item_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        r = apply_request(op, v);
        pending_results.push_back(r);
        num_sent++;
        if (r.status == ST_FULL)
            num_full++;
        if (r.status == ST_ABSENT)
            num_absent++;
        if (r.was_present)
            num_hits++;
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Receiver: draws a stall length per item, or takes a long hold-off when
    // one has been requested, then accepts and checks the next result.
    initial
    begin
        int unsigned n;
        set_result_t want;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
                n = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            num_checked++;
            if (pending_results.size() == 0)
            begin
                num_errors++;
                $display("%0t: result with nothing expected (was_present %0d status %0d count %0d)",
                         $time, was_present, status, member_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (was_present !== want.was_present)
                begin
                    num_errors++;
                    $display("%0t: was_present expected %0d actual %0d",
                             $time, want.was_present, was_present);
                end
                if (status !== want.status)
                begin
                    num_errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                end
                if (member_count !== want.member_count)
                begin
                    num_errors++;
                    $display("%0t: member_count expected %0d actual %0d",
                             $time, want.member_count, member_count);
                end
            end
        end
    end

    // Empty set, extreme values, duplicates, the unused opcode, filling up,
    // a refused add and removes at both ends and in the middle.
    task automatic test_directed();
        send_request(OP_TEST, '0);
        send_request(OP_REMOVE, value_t'(5));
        send_request(OP_ADD, '0);
        send_request(OP_ADD, '1);
        send_request(OP_ADD, '0);
        send_request(OP_UNUSED, '1);
        send_request(OP_UNUSED, value_t'(7));
        send_request(OP_TEST, '1);
        send_request(OP_REMOVE, '0);
        for (int i = 1; i < CAPACITY; i++)
            send_request(OP_ADD, value_t'(32'h8000_0000 + i));
        send_request(OP_ADD, value_t'(32'h0000_1234));
        send_request(OP_REMOVE, value_t'(32'h8000_0008));
        send_request(OP_REMOVE, '1);
        send_request(OP_REMOVE, value_t'(32'h8000_000F));
        wait_all_results();
    endtask

    task automatic test_random_mix(input int unsigned n_items);
        repeat (n_items)
            send_request(pick_op(), pick_value());
    endtask

    // Fill to capacity, push past it, then empty the set in random order.
    task automatic test_fill_drain(input int unsigned rounds);
        repeat (rounds)
        begin
            while (set_size < CAPACITY)
                send_request(OP_ADD, pick_value());
            repeat (3)
                send_request(OP_ADD, value_t'($urandom()));
            send_request(OP_ADD, set_vals[$urandom_range(0, CAPACITY - 1)]);
            send_request(OP_TEST, set_vals[CAPACITY - 1]);
            while (set_size > 0)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_request(OP_REMOVE, value_t'($urandom()));
                send_request(OP_REMOVE, set_vals[$urandom_range(0, set_size - 1)]);
            end
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        tx_idle_on     = 1'b0;
        rx_hold_cycles = 400;
        test_random_mix(60);
        wait_all_results();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_no_idle(input int unsigned n_items);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_mix(n_items);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_TEST;
        item_value     = '0;
        set_size       = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_cycles = 0;
        num_sent       = 0;
        num_checked    = 0;
        num_errors     = 0;
        num_full       = 0;
        num_absent     = 0;
        num_hits       = 0;
        foreach (value_pool[i])
            value_pool[i] = value_t'($urandom());
        value_pool[0] = '0;
        value_pool[1] = '1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(500);
        test_fill_drain(6);
        test_backpressure();
        test_no_idle(300);
        test_random_mix(350);
        wait_all_results();

        if (pending_results.size() != 0)
        begin
            num_errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end
        $display("Sent %0d requests and checked %0d results, with random idling and a long hold-off.",
                 num_sent, num_checked);
        $display("Seen: %0d hits, %0d adds refused as full, %0d removes of absent values.",
                 num_hits, num_full, num_absent);
        if (num_errors == 0)
            $display("tb_dedup_set_table: clean");
        else
            $display("tb_dedup_set_table: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/dst_pkg.sv
sv/dst_ram.sv
sv/dedup_set_table.sv
dv/tb_dedup_set_table.sv
